>>> design/srb_pkg.sv
// Package for the sequence reorder buffer.
// Holds field widths, the stored descriptor type and the walk state encoding.
// No dependencies.
`default_nettype none

package srb_pkg;

    // Field widths of one descriptor
    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 16;
    localparam int TAG_W  = 16;
    localparam int DATA_W = SEQ_W + LEN_W + TAG_W;

    // Slot remainder unit: bits of the sequence number folded per cycle
    localparam int MOD_DIGITS = 8;
    localparam int MOD_CYCLES = SEQ_W / MOD_DIGITS;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    // Stored descriptor, sequence number in the lowest bits
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;
    } t_desc;

    // Control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WRD,
        S_WCMP,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

>>> design/srb_slot_mod.sv
// Slot index unit: remainder of a sequence number by the pool depth.
// Restoring remainder, MOD_DIGITS bits per cycle; uses srb_pkg.
`default_nettype none

module srb_slot_mod #(
    parameter int POOL_DEPTH = 64,
    parameter int SLOT_W     = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [srb_pkg::SEQ_W-1:0] i_seq,
    output logic                           o_done,
    output logic [SLOT_W-1:0]              o_slot
);

    localparam logic [SLOT_W:0] DEP = (SLOT_W + 1)'(POOL_DEPTH);

    logic                           r_busy;
    logic                           r_done;
    logic [srb_pkg::MOD_CNT_W-1:0]  r_cnt;
    logic [srb_pkg::SEQ_W-1:0]      r_shift;
    logic [SLOT_W-1:0]              r_rem;
    logic [SLOT_W-1:0]              n_rem;

    // Fold the next group of bits into the running remainder
    always_comb begin
        logic [SLOT_W:0]   t;
        logic [SLOT_W-1:0] rem;
        rem = r_rem;
        for (int i = 0; i < srb_pkg::MOD_DIGITS; i++) begin
            t = {rem, r_shift[srb_pkg::SEQ_W-1-i]};
            if (t >= DEP) begin
                t = t - DEP;
            end
            rem = t[SLOT_W-1:0];
        end
        n_rem = rem;
    end

    // Control: busy while the groups are folded, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == srb_pkg::MOD_CNT_W'(srb_pkg::MOD_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load the number, then shift it out a group at a time
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_seq;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << srb_pkg::MOD_DIGITS;
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;

endmodule

`default_nettype wire

>>> design/srb_desc_mem.sv
// Descriptor store: one write port, one read port, registered read data.
// Uses srb_pkg for the descriptor type.
`default_nettype none

module srb_desc_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [ADDR_W-1:0]   i_waddr,
    input  wire srb_pkg::t_desc      i_wdata,
    input  wire logic                i_re,
    input  wire logic [ADDR_W-1:0]   i_raddr,
    output srb_pkg::t_desc           o_rdata
);

    srb_pkg::t_desc r_mem [DEPTH];
    srb_pkg::t_desc r_rdata;

    // Write a descriptor into its slot
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read on request, hold the data otherwise
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: sequencer, slot valid bits, output register.
// Depends on srb_pkg, srb_slot_mod and srb_desc_mem.
//
//   channel | direction | tdata (low bit up)                 | tlast
//   s_axis  | in        | seq_num[31:0] pkt_length buffer_tag | -
//   m_axis  | out       | out_seq[31:0] out_length release_tag | last_of_run
//
// A descriptor is taken only when the sequencer is idle. The slot remainder comes
// first, then the store decision; a late word or one whose slot is taken is dropped.
// A stored word then walks the pool, each released word taking a memory read and a
// compare (S_WRD, S_WCMP), and S_FLUSH closes the run.
// Reset clears the expected number, its slot, the slot valid bits and the output valid.
// A stalled m_axis holds the walk, and with it the input side, which is taken only when idle.
`default_nettype none

module sequence_reorder_buffer #(
    parameter int POOL_DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [srb_pkg::DATA_W-1:0] s_axis_tdata,  // seq_num, pkt_length, buffer_tag
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [srb_pkg::DATA_W-1:0]      m_axis_tdata,  // out_seq, out_length, release_tag
    output logic                            m_axis_tlast   // last_of_run
);

    localparam int SLOT_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_DEPTH - 1);

    srb_pkg::t_state r_state;
    srb_pkg::t_state n_state;

    srb_pkg::t_desc            r_in;
    srb_pkg::t_desc            r_pend;
    srb_pkg::t_desc            r_out;
    srb_pkg::t_desc            rd_data;
    logic                      r_pend_valid;
    logic                      r_out_valid;
    logic                      r_out_last;
    logic [srb_pkg::SEQ_W-1:0] r_exp;
    logic [SLOT_W-1:0]         r_exp_slot;
    logic [POOL_DEPTH-1:0]     r_valid;

    logic              in_accept;
    logic              out_free;
    logic              mod_done;
    logic [SLOT_W-1:0] mod_slot;
    logic              mem_we;
    logic              mem_re;
    logic              set_valid;
    logic              clr_valid;
    logic              push;
    logic              push_last;
    logic              load_pend;
    logic              clr_pend;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    // Slot index of the arriving number
    srb_slot_mod #(
        .POOL_DEPTH (POOL_DEPTH),
        .SLOT_W     (SLOT_W)
    ) u_slot_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_seq   (s_axis_tdata[srb_pkg::SEQ_W-1:0]),
        .o_done  (mod_done),
        .o_slot  (mod_slot)
    );

    // Descriptor store
    srb_desc_mem #(
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_desc_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mod_slot),
        .i_wdata (r_in),
        .i_re    (mem_re),
        .i_raddr (r_exp_slot),
        .o_rdata (rd_data)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        set_valid     = 1'b0;
        clr_valid     = 1'b0;
        push          = 1'b0;
        push_last     = 1'b0;
        load_pend     = 1'b0;
        clr_pend      = 1'b0;
        case (r_state)
            srb_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = srb_pkg::S_MOD;
                end
            end
            srb_pkg::S_MOD: begin
                if (mod_done) begin
                    // Drop late words and words whose slot is taken
                    if ((r_in.seq < r_exp) || r_valid[mod_slot]) begin
                        n_state = srb_pkg::S_IDLE;
                    end else begin
                        mem_we    = 1'b1;
                        set_valid = 1'b1;
                        n_state   = srb_pkg::S_WRD;
                    end
                end
            end
            srb_pkg::S_WRD: begin
                if (r_valid[r_exp_slot]) begin
                    mem_re  = 1'b1;
                    n_state = srb_pkg::S_WCMP;
                end else begin
                    n_state = srb_pkg::S_FLUSH;
                end
            end
            srb_pkg::S_WCMP: begin
                if (rd_data.seq != r_exp) begin
                    n_state = srb_pkg::S_FLUSH;
                end else if (!r_pend_valid || out_free) begin
                    // Release: earlier word goes out, this one waits for its mark
                    push      = r_pend_valid;
                    load_pend = 1'b1;
                    clr_valid = 1'b1;
                    n_state   = srb_pkg::S_WRD;
                end
            end
            srb_pkg::S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = srb_pkg::S_IDLE;
                end else if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    clr_pend  = 1'b1;
                    n_state   = srb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srb_pkg::S_IDLE;
            end
        endcase
    end

    // Expected number, its slot, slot valid bits and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp        <= '0;
            r_exp_slot   <= '0;
            r_valid      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (set_valid) begin
                r_valid[mod_slot] <= 1'b1;
            end
            if (clr_valid) begin
                r_valid[r_exp_slot] <= 1'b0;
                r_exp               <= r_exp + 1'b1;
                // Restart the slot count at the last slot and when the number wraps
                r_exp_slot          <= (r_exp_slot == LAST_SLOT || &r_exp) ? '0 :
                                       r_exp_slot + 1'b1;
            end
            if (load_pend) begin
                r_pend_valid <= 1'b1;
            end else if (clr_pend) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= s_axis_tdata;
        end
        if (load_pend) begin
            r_pend <= rd_data;
        end
        if (push) begin
            r_out      <= r_pend;
            r_out_last <= push_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
